>>> src/c2s_pkg.sv
// shared constants, types and helper functions for the cartesian to spherical converter
package c2s_pkg;

  localparam int CORDIC_STEPS = 28;
  localparam int CORDIC_W     = 36;
  localparam int ANG_W        = 31;
  localparam int ANGLE_Q_W    = 32;

  localparam int AZ_W  = 25;
  localparam int EL_W  = 24;
  localparam int RAD_W = 24;

  localparam int PROD_W    = 62;
  localparam int DEG_SHIFT = 52;
  localparam int RAD_PRESHIFT = 24;

  localparam logic [ANGLE_Q_W-1:0] PI_Q28      = 32'd843314857;
  localparam logic [ANGLE_Q_W-1:0] HALF_PI_Q28 = 32'd421657428;
  localparam logic [ANGLE_Q_W-1:0] TWO_PI_Q28  = 32'd1686629714;
  localparam logic [29:0]          DEG_PER_RAD_Q24 = 30'd961263669;

  // either a fixed angle, or a base that the cordic result is added to
  typedef struct packed {
    logic                 special;
    logic [ANGLE_Q_W-1:0] angle;
  } hp_sel_t;

  function automatic logic [27:0] atan_q28(input int unsigned i);
    logic [27:0] v;
    case (i)
      0:       v = 28'd210828714;
      1:       v = 28'd124459457;
      2:       v = 28'd65760959;
      3:       v = 28'd33381290;
      4:       v = 28'd16755422;
      5:       v = 28'd8385879;
      6:       v = 28'd4193963;
      7:       v = 28'd2097109;
      8:       v = 28'd1048571;
      9:       v = 28'd524287;
      10:      v = 28'd262144;
      11:      v = 28'd131072;
      12:      v = 28'd65536;
      13:      v = 28'd32768;
      14:      v = 28'd16384;
      15:      v = 28'd8192;
      16:      v = 28'd4096;
      17:      v = 28'd2048;
      18:      v = 28'd1024;
      19:      v = 28'd512;
      20:      v = 28'd256;
      21:      v = 28'd128;
      22:      v = 28'd64;
      23:      v = 28'd32;
      24:      v = 28'd16;
      25:      v = 28'd8;
      26:      v = 28'd4;
      27:      v = 28'd2;
      default: v = 28'd0;
    endcase
    return v;
  endfunction

  // number of significant bits, zero for zero
  function automatic logic [6:0] bit_len64(input logic [63:0] v);
    logic [6:0] len;
    len = 7'd0;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) len = 7'(i + 1);
    end
    return len;
  endfunction

  // limit a cordic angle to [0, quarter turn]
  function automatic logic [ANGLE_Q_W-1:0] clamp_q28(input logic signed [ANG_W-1:0] a);
    logic [ANGLE_Q_W-1:0] r;
    if (a[ANG_W-1]) r = '0;
    else if (ANGLE_Q_W'(a) > HALF_PI_Q28) r = HALF_PI_Q28;
    else r = ANGLE_Q_W'(a);
    return r;
  endfunction

endpackage

>>> src/c2s_delay.sv
// delay line of registers that advance with the pipeline enable
module c2s_delay #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);
  logic [W-1:0] tap [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      tap[0] <= d;
      for (int i = 1; i < DEPTH; i++) tap[i] <= tap[i-1];
    end
  end

  assign q = tap[DEPTH-1];
endmodule

>>> src/c2s_isqrt.sv
// pipelined integer square root, one result bit per stage
module c2s_isqrt #(
  parameter int IN_W = 48
) (
  input  logic              clk,
  input  logic              en,
  input  logic [IN_W-1:0]   radicand,
  output logic [IN_W/2-1:0] root
);
  localparam int N  = IN_W / 2;
  localparam int RW = N + 3;

  logic [IN_W-1:0] rad_q  [N];
  logic [RW-1:0]   rem_q  [N];
  logic [N-1:0]    root_q [N];

  for (genvar j = 0; j < N; j++) begin : g_stage
    logic [IN_W-1:0] rad_in;
    logic [RW-1:0]   rem_in;
    logic [N-1:0]    root_in;
    logic [RW-1:0]   trial_rem;
    logic [RW-1:0]   trial;

    if (j == 0) begin : g_first
      assign rad_in  = radicand;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign rad_in  = rad_q[j-1];
      assign rem_in  = rem_q[j-1];
      assign root_in = root_q[j-1];
    end

    assign trial_rem = {rem_in[RW-3:0], rad_in[IN_W-1 -: 2]};
    assign trial     = {1'b0, root_in, 2'b01};

    always_ff @(posedge clk) begin
      if (en) begin
        rad_q[j] <= rad_in << 2;
        if (trial_rem >= trial) begin
          rem_q[j]  <= trial_rem - trial;
          root_q[j] <= {root_in[N-2:0], 1'b1};
        end else begin
          rem_q[j]  <= trial_rem;
          root_q[j] <= {root_in[N-2:0], 1'b0};
        end
      end
    end
  end

  assign root = root_q[N-1];
endmodule

>>> src/c2s_cordic.sv
// pipelined vectoring cordic, one micro-rotation per stage, angle in q.28
module c2s_cordic (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic signed [c2s_pkg::CORDIC_W-1:0]  x_in,
  input  logic signed [c2s_pkg::CORDIC_W-1:0]  y_in,
  output logic signed [c2s_pkg::ANG_W-1:0]     ang
);
  import c2s_pkg::*;

  logic signed [CORDIC_W-1:0] xq [CORDIC_STEPS];
  logic signed [CORDIC_W-1:0] yq [CORDIC_STEPS];
  logic signed [ANG_W-1:0]    aq [CORDIC_STEPS];

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_stage
    localparam logic signed [ANG_W-1:0] STEP = ANG_W'(atan_q28(i));
    logic signed [CORDIC_W-1:0] xi;
    logic signed [CORDIC_W-1:0] yi;
    logic signed [ANG_W-1:0]    ai;

    if (i == 0) begin : g_first
      assign xi = x_in;
      assign yi = y_in;
      assign ai = '0;
    end else begin : g_next
      assign xi = xq[i-1];
      assign yi = yq[i-1];
      assign ai = aq[i-1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (!yi[CORDIC_W-1]) begin
          xq[i] <= xi + (yi >>> i);
          yq[i] <= yi - (xi >>> i);
          aq[i] <= ai + STEP;
        end else begin
          xq[i] <= xi - (yi >>> i);
          yq[i] <= yi + (xi >>> i);
          aq[i] <= ai - STEP;
        end
      end
    end
  end

  assign ang = aq[CORDIC_STEPS-1];
endmodule

>>> src/c2s_units.sv
// q.28 radians to output units (radians or degrees), rounding and full-turn wrap
module c2s_units #(
  parameter int FRAC = 16
) (
  input  logic                                   clk,
  input  logic                                   en,
  input  logic                                   degrees,
  input  logic [c2s_pkg::ANGLE_Q_W-1:0]          angle,
  output logic [c2s_pkg::PROD_W - c2s_pkg::DEG_SHIFT + FRAC - 1:0] result
);
  import c2s_pkg::*;

  localparam int S  = DEG_SHIFT - FRAC;
  localparam int OW = PROD_W - S;
  localparam logic [63:0] HALF = 64'd1 << (S - 1);
  localparam logic [63:0] FULL_DEG =
    (64'(TWO_PI_Q28) * 64'(DEG_PER_RAD_Q24) + HALF) >> S;
  localparam logic [63:0] FULL_RAD =
    ((64'(TWO_PI_Q28) << RAD_PRESHIFT) + HALF) >> S;

  logic [PROD_W-1:0] scaled;
  logic [OW-1:0]     rounded;
  logic [63:0]       full;

  // radians are lifted by 24 bits so both units share one rounding shift
  always_ff @(posedge clk) begin
    if (en) begin
      if (degrees) scaled <= PROD_W'(angle) * PROD_W'(DEG_PER_RAD_Q24);
      else         scaled <= PROD_W'(angle) << RAD_PRESHIFT;
      rounded <= OW'((64'(scaled) + HALF) >> S);
      if (64'(rounded) >= full) result <= OW'(64'(rounded) - full);
      else                      result <= rounded;
    end
  end

  assign full = degrees ? FULL_DEG : FULL_RAD;
endmodule

>>> src/cartesian_to_spherical.sv
// top level: pipelined cartesian to spherical conversion
// one vector per cycle sustained while the output is not stalled
// the elevation path sets the depth: 32-stage square root of the scaled plane radius
// followed by a 28-stage cordic; the whole pipe holds on an output stall
// reset (synchronous) clears every valid bit and selects radians
// configuration is taken at any cycle, cfg_ready is always high
module cartesian_to_spherical #(
  parameter int COORD_WIDTH     = 24,
  parameter int ANGLE_FRAC_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic                                  cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [COORD_WIDTH-1:0]         coord_x,
  input  logic signed [COORD_WIDTH-1:0]         coord_y,
  input  logic signed [COORD_WIDTH-1:0]         coord_z,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [c2s_pkg::AZ_W-1:0]              azimuth,
  output logic [c2s_pkg::EL_W-1:0]              elevation,
  output logic [c2s_pkg::RAD_W-1:0]             radius,
  output logic                                  zero_vector
);
  import c2s_pkg::*;

  localparam int CW   = COORD_WIDTH;
  localparam int SQ_W = 2 * CW;
  localparam int UW   = PROD_W - DEG_SHIFT + ANGLE_FRAC_BITS;
  localparam int LAT  = 71;

  // stage numbers: tN is the register of pipeline stage N after the transfer
  localparam int T_RADIUS = 3 + CW;
  localparam int T_AZ_OUT = 37;
  localparam int T_EL_OUT = 70;

  logic angle_in_degrees;
  logic en;
  logic [LAT-1:0] vld;

  // stage 1: magnitudes and signs
  logic [CW-1:0] mx1, my1, mz1;
  logic          xneg1, yneg1, zneg1;
  // stage 2: squares
  logic [SQ_W-1:0] sqx2, sqy2, sqz2;
  logic [CW-1:0]   mx2, my2, mz2;
  logic            xneg2, yneg2, zneg2;
  // stage 3: sums and azimuth set-up
  logic [SQ_W-1:0] pr2_3, r2_3;
  logic [CW-1:0]   ca3, cb3, mz3;
  logic [4:0]      s3;
  logic            yneg3, zneg3, zero3;
  hp_sel_t         az_sel3;
  logic [6:0]      az_len;
  // stage 4: normalised azimuth operands, elevation scale
  logic signed [CORDIC_W-1:0] ax4, ay4;
  logic [5:0]      k4;
  logic [SQ_W-1:0] pr2_4;
  logic [CW-1:0]   mz4;
  logic            zneg4, yneg4;
  hp_sel_t         az_sel4;
  // stage 5: scaled plane radius square and z
  logic [63:0]     p5;
  logic [31:0]     zs5;
  logic            zneg5;

  // azimuth tail
  logic signed [ANG_W-1:0] az_ang32;
  hp_sel_t                 az_sel32;
  logic                    yneg32, yneg33;
  logic [ANGLE_Q_W-1:0]    az_th33, az_th34;
  logic [UW-1:0]           az_u37, az_u70;

  // elevation
  logic [31:0]             prs37, zs37;
  logic                    zneg37;
  logic signed [CORDIC_W-1:0] ea38, eb38;
  hp_sel_t                 el_sel38, el_sel66;
  logic signed [ANG_W-1:0] el_ang66;
  logic [ANGLE_Q_W-1:0]    el_th67;
  logic [UW-1:0]           el_u70;

  logic [CW-1:0]  rad_root;
  logic [CW-1:0]  rad70;
  logic           zero70;

  // whole pipe moves together unless a result is waiting and not taken
  assign en        = !out_valid || out_ready;
  assign in_ready  = en;
  assign out_valid = vld[LAT-1];
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      angle_in_degrees <= 1'b0;
    end else if (cfg_valid) begin
      angle_in_degrees <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  assign az_len = bit_len64(64'(mx2 | my2));

  always_ff @(posedge clk) begin
    if (en) begin
      // stage 1
      mx1   <= coord_x[CW-1] ? CW'(-coord_x) : CW'(coord_x);
      my1   <= coord_y[CW-1] ? CW'(-coord_y) : CW'(coord_y);
      mz1   <= coord_z[CW-1] ? CW'(-coord_z) : CW'(coord_z);
      xneg1 <= coord_x[CW-1];
      yneg1 <= coord_y[CW-1];
      zneg1 <= coord_z[CW-1];

      // stage 2
      sqx2  <= SQ_W'(mx1) * SQ_W'(mx1);
      sqy2  <= SQ_W'(my1) * SQ_W'(my1);
      sqz2  <= SQ_W'(mz1) * SQ_W'(mz1);
      mx2   <= mx1;
      my2   <= my1;
      mz2   <= mz1;
      xneg2 <= xneg1;
      yneg2 <= yneg1;
      zneg2 <= zneg1;

      // stage 3: left half-plane folds to a quarter turn plus atan(|x| / |y|)
      pr2_3 <= sqx2 + sqy2;
      r2_3  <= sqx2 + sqy2 + sqz2;
      zero3 <= (mx2 | my2 | mz2) == '0;
      ca3   <= xneg2 ? my2 : mx2;
      cb3   <= xneg2 ? mx2 : my2;
      s3    <= (az_len >= 7'd31) ? 5'd0 : 5'(7'd31 - az_len);
      mz3   <= mz2;
      yneg3 <= yneg2;
      zneg3 <= zneg2;
      if (my2 == '0) begin
        az_sel3.special <= 1'b1;
        az_sel3.angle   <= xneg2 ? PI_Q28 : '0;
      end else if (mx2 == '0) begin
        az_sel3.special <= 1'b1;
        az_sel3.angle   <= HALF_PI_Q28;
      end else begin
        az_sel3.special <= 1'b0;
        az_sel3.angle   <= xneg2 ? HALF_PI_Q28 : '0;
      end

      // stage 4: double both operands until one reaches 2^30
      ax4     <= CORDIC_W'(ca3) << s3;
      ay4     <= CORDIC_W'(cb3) << s3;
      k4      <= 6'((7'd64 - bit_len64(64'(r2_3))) >> 1);
      pr2_4   <= pr2_3;
      mz4     <= mz3;
      zneg4   <= zneg3;
      yneg4   <= yneg3;
      az_sel4 <= az_sel3;

      // stage 5: scale by 4^k and 2^k so the square fills 64 bits
      p5    <= 64'(pr2_4) << {k4, 1'b0};
      zs5   <= 32'(mz4) << k4;
      zneg5 <= zneg4;

      // azimuth: combine, then mirror for negative y
      az_th33 <= az_sel32.special ? az_sel32.angle
                                  : az_sel32.angle + clamp_q28(az_ang32);
      yneg33  <= yneg32;
      az_th34 <= yneg33 ? TWO_PI_Q28 - az_th33 : az_th33;

      // elevation set-up, the larger operand already at least 2^30 from the scaling
      ea38 <= CORDIC_W'(zneg37 ? prs37 : zs37);
      eb38 <= CORDIC_W'(zneg37 ? zs37 : prs37);
      if (prs37 == '0) begin
        el_sel38.special <= 1'b1;
        el_sel38.angle   <= zneg37 ? PI_Q28 : '0;
      end else if (zs37 == '0) begin
        el_sel38.special <= 1'b1;
        el_sel38.angle   <= HALF_PI_Q28;
      end else begin
        el_sel38.special <= 1'b0;
        el_sel38.angle   <= zneg37 ? HALF_PI_Q28 : '0;
      end

      el_th67 <= el_sel66.special ? el_sel66.angle
                                  : el_sel66.angle + clamp_q28(el_ang66);

      // output register, zero vector forces every field to zero
      zero_vector <= zero70;
      azimuth     <= zero70 ? '0 : AZ_W'(az_u70);
      elevation   <= zero70 ? '0 : EL_W'(el_u70);
      radius      <= zero70 ? '0 : RAD_W'(rad70);
    end
  end

  // radius
  c2s_isqrt #(.IN_W(SQ_W)) u_rad_sqrt (
    .clk(clk), .en(en), .radicand(r2_3), .root(rad_root)
  );
  c2s_delay #(.W(CW), .DEPTH(T_EL_OUT - T_RADIUS)) u_rad_dly (
    .clk(clk), .en(en), .d(rad_root), .q(rad70)
  );
  c2s_delay #(.W(1), .DEPTH(T_EL_OUT - 3)) u_zero_dly (
    .clk(clk), .en(en), .d(zero3), .q(zero70)
  );

  // azimuth
  c2s_cordic u_az_cordic (
    .clk(clk), .en(en), .x_in(ax4), .y_in(ay4), .ang(az_ang32)
  );
  c2s_delay #(.W($bits(hp_sel_t) + 1), .DEPTH(CORDIC_STEPS)) u_az_dly (
    .clk(clk), .en(en), .d({az_sel4, yneg4}), .q({az_sel32, yneg32})
  );
  c2s_units #(.FRAC(ANGLE_FRAC_BITS)) u_az_units (
    .clk(clk), .en(en), .degrees(angle_in_degrees), .angle(az_th34), .result(az_u37)
  );
  c2s_delay #(.W(UW), .DEPTH(T_EL_OUT - T_AZ_OUT)) u_az_out_dly (
    .clk(clk), .en(en), .d(az_u37), .q(az_u70)
  );

  // elevation
  c2s_isqrt #(.IN_W(64)) u_pr_sqrt (
    .clk(clk), .en(en), .radicand(p5), .root(prs37)
  );
  c2s_delay #(.W(33), .DEPTH(32)) u_z_dly (
    .clk(clk), .en(en), .d({zs5, zneg5}), .q({zs37, zneg37})
  );
  c2s_cordic u_el_cordic (
    .clk(clk), .en(en), .x_in(ea38), .y_in(eb38), .ang(el_ang66)
  );
  c2s_delay #(.W($bits(hp_sel_t)), .DEPTH(CORDIC_STEPS)) u_el_dly (
    .clk(clk), .en(en), .d(el_sel38), .q(el_sel66)
  );
  c2s_units #(.FRAC(ANGLE_FRAC_BITS)) u_el_units (
    .clk(clk), .en(en), .degrees(angle_in_degrees), .angle(el_th67), .result(el_u70)
  );

  // zero vector always reports zero fields
  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && zero_vector |-> azimuth == '0 && elevation == '0 && radius == '0)
    else $error("zero vector with non-zero fields");

  // a stall freezes every valid bit
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !in_ready |=> vld == $past(vld))
    else $error("pipeline moved during stall");

  // a result that is taken with nothing behind it leaves the output empty
  a_drain: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !vld[LAT-2] |=> !out_valid)
    else $error("result repeated");
endmodule

>>> tb/sv/tb_cartesian_to_spherical.sv
`timescale 1ns / 100ps
// testbench for the cartesian to spherical converter: directed, random and stall tests
module tb_cartesian_to_spherical;
  import c2s_pkg::*;

  localparam int CW         = 24;
  localparam int FRAC       = 16;
  localparam int LATENCY    = 71;
  localparam int CYCLE_CAP  = 600000;
  localparam int RAND_ITEMS = 2000;
  localparam logic UNITS_RAD = 1'b0;
  localparam logic UNITS_DEG = 1'b1;

  typedef struct packed {
    logic [AZ_W-1:0]  az;
    logic [EL_W-1:0]  el;
    logic [RAD_W-1:0] rad;
    logic             zero;
  } sph_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_data = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [CW-1:0] coord_x = '0;
  logic signed [CW-1:0] coord_y = '0;
  logic signed [CW-1:0] coord_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [AZ_W-1:0]  azimuth;
  logic [EL_W-1:0]  elevation;
  logic [RAD_W-1:0] radius;
  logic             zero_vector;

  // predictor copy of the unit register
  logic units_deg = UNITS_RAD;
  sph_t pending_q[$];
  int   mismatches = 0;
  int   cycles = 0;
  // no idling on either side once set
  bit   calm = 1'b0;
  int   hold_len = 0;

  cartesian_to_spherical #(.COORD_WIDTH(CW), .ANGLE_FRAC_BITS(FRAC)) u_top (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .azimuth(azimuth), .elevation(elevation), .radius(radius),
    .zero_vector(zero_vector)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------- predictor
  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned r, bit_q;
    r = 0;
    bit_q = 64'd1 << 62;
    while (bit_q > v) bit_q = bit_q >> 2;
    while (bit_q != 0) begin
      if (v >= r + bit_q) begin
        v = v - (r + bit_q);
        r = (r >> 1) + bit_q;
      end else begin
        r = r >> 1;
      end
      bit_q = bit_q >> 2;
    end
    return r;
  endfunction

  // vectoring rotation, first quadrant, q28 radians clamped to a quarter turn
  function automatic longint quadrant_angle(input longint a, input longint b);
    longint xa, ya, ang, xn;
    xa = a;
    ya = b;
    ang = 0;
    while (xa < (64'sd1 <<< 30) && ya < (64'sd1 <<< 30)) begin
      xa = xa * 2;
      ya = ya * 2;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      // arithmetic shift of a signed value rounds towards minus infinity
      if (ya >= 0) begin
        xn  = xa + (ya >>> i);
        ya  = ya - (xa >>> i);
        ang = ang + longint'(atan_q28(i));
      end else begin
        xn  = xa - (ya >>> i);
        ya  = ya + (xa >>> i);
        ang = ang - longint'(atan_q28(i));
      end
      xa = xn;
    end
    if (ang < 0) ang = 0;
    if (ang > longint'(HALF_PI_Q28)) ang = longint'(HALF_PI_Q28);
    return ang;
  endfunction

  // angle of (a, b) for b >= 0, over [0, half turn]
  function automatic longint upper_angle(input longint a, input longint b);
    if (b == 0) return (a < 0) ? longint'(PI_Q28) : 0;
    if (a == 0) return longint'(HALF_PI_Q28);
    if (a > 0) return quadrant_angle(a, b);
    return longint'(HALF_PI_Q28) + quadrant_angle(b, -a);
  endfunction

  function automatic longint unsigned scale_angle(input longint q28);
    longint unsigned t;
    t = longint'(q28);
    if (units_deg)
      return (t * longint'(DEG_PER_RAD_Q24) + (64'd1 << (DEG_SHIFT - FRAC - 1)))
             >> (DEG_SHIFT - FRAC);
    return (t + (64'd1 << (28 - FRAC - 1))) >> (28 - FRAC);
  endfunction

  function automatic sph_t spherical_of(input logic signed [CW-1:0] xi,
                                        input logic signed [CW-1:0] yi,
                                        input logic signed [CW-1:0] zi);
    sph_t res;
    longint x, y, z, th, zs, prs;
    longint unsigned mx, my, mz, pr2, r2, az, el, full;
    int k;
    x = xi; y = yi; z = zi;
    mx = (x < 0) ? -x : x;
    my = (y < 0) ? -y : y;
    mz = (z < 0) ? -z : z;
    pr2 = mx * mx + my * my;
    r2 = pr2 + mz * mz;
    res = '0;
    if (r2 == 0) begin
      res.zero = 1'b1;
      return res;
    end
    az = 0;
    if (pr2 != 0) begin
      th = upper_angle(x, longint'(my));
      if (y < 0) th = longint'(TWO_PI_Q28) - th;
      az = scale_angle(th);
      full = scale_angle(longint'(TWO_PI_Q28));
      // rounding up to a whole turn wraps back to zero
      if (az >= full) az = az - full;
    end
    k = 0;
    while (k < 31 && r2 < (64'd1 << (62 - 2 * k))) k++;
    prs = int_sqrt(pr2 << (2 * k));
    zs = mz << k;
    if (z < 0) zs = -zs;
    el = scale_angle(upper_angle(zs, prs));
    res.az   = az[AZ_W-1:0];
    res.el   = el[EL_W-1:0];
    res.rad  = RAD_W'(int_sqrt(r2));
    res.zero = 1'b0;
    return res;
  endfunction

  // ---------------------------------------------------------------- checking
  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
    mismatches++;
  endtask

  // compare each result transfer against the oldest expectation
  always @(posedge clk) begin
    sph_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_q.size() == 0) begin
        report_mismatch("unexpected result", 0, 0);
      end else begin
        want = pending_q.pop_front();
        if (azimuth !== want.az) report_mismatch("azimuth", azimuth, want.az);
        if (elevation !== want.el) report_mismatch("elevation", elevation, want.el);
        if (radius !== want.rad) report_mismatch("radius", radius, want.rad);
        if (zero_vector !== want.zero)
          report_mismatch("zero_vector", zero_vector, want.zero);
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles", cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // receiver: random stall bursts, plus a long hold-off on request
  initial begin
    int idle_left;
    idle_left = 0;
    forever begin
      @(negedge clk);
      if (hold_len > 0) begin
        out_ready <= 1'b0;
        hold_len--;
      end else if (idle_left > 0) begin
        out_ready <= 1'b0;
        idle_left--;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        idle_left = $urandom_range(1, 15) - 1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- driving
  task automatic send_vector(input logic signed [CW-1:0] x, input logic signed [CW-1:0] y,
                             input logic signed [CW-1:0] z);
    @(negedge clk);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    in_valid <= 1'b1;
    coord_x  <= x;
    coord_y  <= y;
    coord_z  <= z;
    do @(posedge clk); while (!in_ready);
    pending_q.push_back(spherical_of(x, y, z));
  endtask

  // hold the input until every expected result has come out
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
  endtask

  // register writes only while the pipe is empty
  task automatic set_units(input logic deg);
    wait_drained();
    repeat (LATENCY + 10) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= deg;
    do @(posedge clk); while (!cfg_ready);
    units_deg = deg;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [CW-1:0] pick_coord();
    case ($urandom_range(0, 5))
      0:       return CW'($urandom_range(0, 64)) - CW'(32);
      1:       return {1'b0, {(CW-1){1'b1}}};
      2:       return {1'b1, {(CW-1){1'b0}}};
      3:       return CW'(0);
      default: return CW'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------- tests
  task automatic test_special_vectors();
    logic signed [CW-1:0] maxv, minv;
    maxv = {1'b0, {(CW-1){1'b1}}};
    minv = {1'b1, {(CW-1){1'b0}}};
    send_vector(0, 0, 0);                 // zero vector flag
    send_vector(0, 0, 5);                 // on +z axis
    send_vector(0, 0, -5);                // on -z axis
    send_vector(7, 0, 0);                 // z zero, quarter turn elevation
    send_vector(-7, 0, 0);                // azimuth half turn
    send_vector(0, 9, 0);
    send_vector(0, -9, 0);
    send_vector(maxv, -1, 0);             // azimuth rounds to a full turn
    send_vector(maxv, maxv, maxv);
    send_vector(minv, minv, minv);
    send_vector(minv, maxv, minv);
    send_vector(maxv, minv, 1);
    send_vector(-1, -1, -1);
    send_vector(1, 1, 1);
    send_vector(3, -4, 12);
    send_vector(0, 0, minv);
  endtask

  task automatic test_random_vectors(input int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 3) == 0)
        send_vector(pick_coord(), pick_coord(), pick_coord());
      else
        send_vector(CW'($urandom), CW'($urandom), CW'($urandom));
    end
  endtask

  // long receiver hold-off while the sender keeps offering, so the input stalls
  task automatic test_backpressure();
    hold_len = 300;
    test_random_vectors(120);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_special_vectors();
    set_units(UNITS_DEG);
    test_special_vectors();
    set_units(UNITS_RAD);
    test_random_vectors(RAND_ITEMS / 4);
    test_backpressure();
    set_units(UNITS_DEG);
    test_random_vectors(RAND_ITEMS / 4);
    wait_drained();
    test_random_vectors(RAND_ITEMS / 8);
    set_units(UNITS_RAD);
    test_random_vectors(RAND_ITEMS / 8);
    set_units(UNITS_DEG);
    calm = 1'b1;
    test_random_vectors(RAND_ITEMS / 4);

    wait_drained();
    repeat (LATENCY + 20) @(posedge clk);
    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
